>>> sv/mlrr_pkg.sv
// Package for the multilevel round-robin scheduler: word types, codes, defaults.
// No dependencies.
`default_nettype none
package mlrr_pkg;

  localparam int unsigned NumTasksDef      = 64;
  localparam int unsigned TasksPerLevelDef = 16;
  localparam int unsigned NumLevelsDef     = 8;

  localparam int unsigned TaskW  = 6;
  localparam int unsigned LevelW = 4;

  typedef enum logic [1:0] {
    REQ_RUN   = 2'd0,
    REQ_SLEEP = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_QUERY = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [TaskW-1:0]         task_id;
    logic signed [LevelW-1:0] level;
  } in_word_t;

  typedef struct packed {
    logic [TaskW-1:0] result_task;
    logic             do_switch;
    logic             no_runnable;
    logic [1:0]       status;
  } out_word_t;

endpackage
`default_nettype wire

>>> sv/mlrr_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module mlrr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

>>> sv/mlrr_fifo.sv
// Two-entry word queue between front and back.
// Depends on mlrr_pkg.
`default_nettype none
module mlrr_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  mlrr_pkg::in_word_t      wdata_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    empty_o,
  output mlrr_pkg::in_word_t      rdata_o
);
  import mlrr_pkg::*;

  in_word_t   buf_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign rdata_o = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule
`default_nettype wire

>>> sv/mlrr_exec.sv
// Back end: sequencer that carries out one request against the level lists.
// Depends on mlrr_pkg and mlrr_ram.
`default_nettype none
module mlrr_exec #(
  parameter int unsigned NumTasks      = mlrr_pkg::NumTasksDef,
  parameter int unsigned TasksPerLevel = mlrr_pkg::TasksPerLevelDef,
  parameter int unsigned NumLevels     = mlrr_pkg::NumLevelsDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           req_valid_i,
  input  mlrr_pkg::in_word_t  req_i,
  output logic                req_pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output mlrr_pkg::out_word_t out_o
);
  import mlrr_pkg::*;

  localparam int unsigned TIdxW     = (NumTasks > 1) ? $clog2(NumTasks) : 1;
  localparam int unsigned PosW      = (TasksPerLevel > 1) ? $clog2(TasksPerLevel) : 1;
  localparam int unsigned CntW      = $clog2(TasksPerLevel + 1);
  localparam int unsigned LvW       = $clog2(NumLevels + 1);
  localparam int unsigned LIdxW     = (NumLevels > 1) ? $clog2(NumLevels) : 1;
  localparam int unsigned ListDepth = NumLevels * TasksPerLevel;
  localparam int unsigned AddrW     = $clog2(ListDepth);
  localparam int unsigned TsW       = LIdxW + 1;

  typedef enum logic [11:0] {
    S_CLR    = 12'b000000000001,
    S_IDLE   = 12'b000000000010,
    S_DEC    = 12'b000000000100,
    S_FIND   = 12'b000000001000,
    S_FCHK   = 12'b000000010000,
    S_SHRD   = 12'b000000100000,
    S_SHWR   = 12'b000001000000,
    S_RMD    = 12'b000010000000,
    S_APPEND = 12'b000100000000,
    S_SEL    = 12'b001000000000,
    S_RD     = 12'b010000000000,
    S_OUT    = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  // per-level state in flops
  logic [TIdxW-1:0] clr_q;
  logic [CntW-1:0]  cnt_q [NumLevels];
  logic [PosW-1:0]  rot_q [NumLevels];
  logic [LvW-1:0]   cur_q;
  logic             review_q, idle_q;

  in_word_t         w_q;
  logic [LIdxW-1:0] lv_q, olv_q;
  logic [CntW-1:0]  i_q;
  logic             prev_ok_q, append_q, sleepsel_q, mark_q, emptied_q;
  logic [TaskW-1:0] prev_task_q;
  status_e          status_q;
  out_word_t        out_q;
  logic             ovalid_q;

  // task RAM: {running, prio} per task, cleared after reset
  logic             ts_we;
  logic [TIdxW-1:0] ts_addr;
  logic [TsW-1:0]   ts_wdata, ts_rdata;

  mlrr_ram #(.Width(TsW), .Depth(NumTasks)) u_task (
    .clk_i, .we_i(ts_we), .addr_i(ts_addr), .wdata_i(ts_wdata), .rdata_o(ts_rdata)
  );

  // list RAM: run lists, one row of TasksPerLevel entries per level
  logic             lst_we;
  logic [AddrW-1:0] lst_addr;
  logic [TaskW-1:0] lst_wdata, lst_rdata;

  mlrr_ram #(.Width(TaskW), .Depth(ListDepth)) u_list (
    .clk_i, .we_i(lst_we), .addr_i(lst_addr), .wdata_i(lst_wdata), .rdata_o(lst_rdata)
  );

  function automatic logic [AddrW-1:0] adr(logic [LIdxW-1:0] l, logic [CntW-1:0] p);
    return AddrW'(int'(l) * TasksPerLevel + int'(p));
  endfunction

  // lowest-numbered non-empty level
  logic [LvW-1:0] top_lv;
  logic           any_run;
  always_comb begin
    top_lv  = LvW'(NumLevels);
    any_run = 1'b0;
    for (int k = NumLevels - 1; k >= 0; k--) begin
      if (cnt_q[k] != '0) begin
        top_lv  = LvW'(k);
        any_run = 1'b1;
      end
    end
  end

  logic [LIdxW-1:0] cur_idx;
  logic             cur_ok;
  assign cur_idx = cur_q[LIdxW-1:0];
  assign cur_ok  = (cur_q < LvW'(NumLevels)) && (cnt_q[cur_idx] != '0);

  // request decode, valid in S_DEC (task RAM read during S_IDLE)
  logic             ts_run;
  logic [LIdxW-1:0] ts_prio;
  logic [TIdxW-1:0] t_idx;
  logic             t_ok, is_run, is_sleep, is_tick;
  assign ts_run   = ts_rdata[TsW-1];
  assign ts_prio  = ts_rdata[LIdxW-1:0];
  assign t_idx    = TIdxW'(w_q.task_id);
  assign t_ok     = ({1'b0, w_q.task_id} < (TaskW+1)'(NumTasks));
  assign is_run   = (w_q.req_type == REQ_RUN);
  assign is_sleep = (w_q.req_type == REQ_SLEEP);
  assign is_tick  = (w_q.req_type == REQ_TICK);

  logic [LIdxW-1:0] dec_lv;
  logic             dec_lv_ok;
  always_comb begin
    dec_lv    = ts_prio;
    dec_lv_ok = 1'b1;
    if (!w_q.level[LevelW-1]) begin
      dec_lv    = w_q.level[LIdxW-1:0];
      dec_lv_ok = ({1'b0, w_q.level} < (LevelW+1)'(NumLevels));
    end
  end

  logic run_go, run_dup, run_full, run_app, sleep_go;
  assign run_go   = is_run && t_ok && dec_lv_ok;
  assign run_dup  = ts_run && (ts_prio == dec_lv);
  assign run_full = (cnt_q[dec_lv] >= CntW'(TasksPerLevel));
  assign run_app  = run_go && !run_dup && !run_full;
  assign sleep_go = is_sleep && t_ok && ts_run;

  status_e dec_status;
  always_comb begin
    dec_status = ST_DONE;
    if (is_run) begin
      if (!run_go || run_dup) dec_status = ST_IGNORED;
      else if (run_full)      dec_status = ST_FULL;
    end else if (is_sleep && !sleep_go) begin
      dec_status = ST_IGNORED;
    end
  end

  logic tick_wrap;
  assign tick_wrap = (CntW'(rot_q[cur_idx]) + 1'b1 >= cnt_q[cur_idx]);

  // removal: search hit and pointer fix
  logic            f_miss, f_hit;
  logic [CntW-1:0] n_new, rot_w, rot_dec, rot_fix;
  assign f_miss  = (i_q >= cnt_q[olv_q]);
  assign f_hit   = !f_miss && (lst_rdata == w_q.task_id);
  assign n_new   = cnt_q[olv_q] - 1'b1;
  assign rot_w   = CntW'(rot_q[olv_q]);
  assign rot_dec = (i_q < rot_w) ? rot_w - 1'b1 : rot_w;
  assign rot_fix = (rot_dec >= n_new) ? '0 : rot_dec;

  logic out_load;
  assign out_load    = (state_q == S_OUT) && (!ovalid_q || out_ready_i);
  assign req_pop_o   = (state_q == S_IDLE) && req_valid_i;
  assign out_valid_o = ovalid_q;
  assign out_o       = out_q;

  always_comb begin
    ts_we    = 1'b0;
    ts_addr  = TIdxW'(req_i.task_id);
    ts_wdata = '0;
    case (state_q)
      S_CLR: begin
        ts_we   = 1'b1;
        ts_addr = clr_q;
      end
      S_DEC: begin
        ts_we    = sleep_go;
        ts_addr  = t_idx;
        ts_wdata = {1'b0, ts_prio};
      end
      S_APPEND: begin
        ts_we    = 1'b1;
        ts_addr  = t_idx;
        ts_wdata = {1'b1, lv_q};
      end
      default: ;
    endcase
  end

  always_comb begin
    lst_we    = 1'b0;
    lst_addr  = adr(cur_idx, CntW'(rot_q[cur_idx]));
    lst_wdata = lst_rdata;
    case (state_q)
      S_FIND: lst_addr = adr(olv_q, i_q);
      S_SHRD: lst_addr = adr(olv_q, i_q + 1'b1);
      S_SHWR: begin
        lst_we   = 1'b1;
        lst_addr = adr(olv_q, i_q);
      end
      S_APPEND: begin
        lst_we    = 1'b1;
        lst_addr  = adr(lv_q, cnt_q[lv_q]);
        lst_wdata = w_q.task_id;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR:    if (clr_q == TIdxW'(NumTasks - 1)) state_d = S_IDLE;
      S_IDLE:   if (req_valid_i) state_d = S_DEC;
      S_DEC: begin
        if ((run_app && ts_run) || sleep_go) state_d = S_FIND;
        else if (run_app)                    state_d = S_APPEND;
        else                                 state_d = S_SEL;
      end
      S_FIND:   state_d = S_FCHK;
      S_FCHK: begin
        if (f_hit)       state_d = (i_q < n_new) ? S_SHRD : S_RMD;
        else if (f_miss) state_d = S_RMD;
        else             state_d = S_FIND;
      end
      S_SHRD:   state_d = S_SHWR;
      S_SHWR:   state_d = (i_q + 1'b1 < cnt_q[olv_q]) ? S_SHRD : S_RMD;
      S_RMD:    state_d = append_q ? S_APPEND : S_SEL;
      S_APPEND: state_d = S_SEL;
      S_SEL:    state_d = S_RD;
      S_RD:     state_d = S_OUT;
      S_OUT:    if (out_load) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (req_pop_o) w_q <= req_i;
    if (out_load) begin
      out_q.result_task <= cur_ok ? lst_rdata : '0;
      out_q.do_switch   <= cur_ok && (!prev_ok_q || prev_task_q != lst_rdata);
      out_q.no_runnable <= !any_run;
      out_q.status      <= status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      for (int k = 0; k < NumLevels; k++) begin
        cnt_q[k] <= '0;
        rot_q[k] <= '0;
      end
      cur_q       <= LvW'(NumLevels);
      review_q    <= 1'b0;
      idle_q      <= 1'b1;
      ovalid_q    <= 1'b0;
      lv_q        <= '0;
      olv_q       <= '0;
      i_q         <= '0;
      prev_ok_q   <= 1'b0;
      prev_task_q <= '0;
      append_q    <= 1'b0;
      sleepsel_q  <= 1'b0;
      mark_q      <= 1'b0;
      emptied_q   <= 1'b0;
      status_q    <= ST_DONE;
    end else begin
      state_q <= state_d;
      if (out_load)         ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
      case (state_q)
        S_CLR: clr_q <= clr_q + 1'b1;
        S_DEC: begin
          // list RAM output holds the selected entry read during S_IDLE
          prev_ok_q   <= cur_ok;
          prev_task_q <= lst_rdata;
          lv_q        <= dec_lv;
          olv_q       <= ts_prio;
          i_q         <= '0;
          append_q    <= run_app;
          sleepsel_q  <= sleep_go && cur_ok && (lst_rdata == w_q.task_id);
          mark_q      <= run_go;
          emptied_q   <= 1'b0;
          status_q    <= dec_status;
          if (is_tick && !idle_q) begin
            if (cur_ok) begin
              if (tick_wrap) rot_q[cur_idx] <= '0;
              else           rot_q[cur_idx] <= rot_q[cur_idx] + 1'b1;
            end
            if (review_q) begin
              cur_q    <= top_lv;
              review_q <= 1'b0;
              idle_q   <= !any_run;
            end
          end
        end
        S_FCHK: begin
          // one entry checked per pass
          if (f_hit) begin
            cnt_q[olv_q] <= n_new;
            rot_q[olv_q] <= rot_fix[PosW-1:0];
            emptied_q    <= (n_new == '0);
          end else if (!f_miss) begin
            i_q <= i_q + 1'b1;
          end
        end
        S_SHWR: if (i_q + 1'b1 < cnt_q[olv_q]) i_q <= i_q + 1'b1;
        S_RMD: begin
          // level emptied: reselect before any append
          if (emptied_q) begin
            cur_q    <= top_lv;
            review_q <= 1'b0;
            idle_q   <= !any_run;
          end
        end
        S_APPEND: begin
          cnt_q[lv_q] <= cnt_q[lv_q] + 1'b1;
          idle_q      <= 1'b0;
        end
        S_SEL: begin
          if (sleepsel_q) begin
            cur_q    <= top_lv;
            review_q <= 1'b0;
            idle_q   <= !any_run;
          end else if (mark_q) begin
            review_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> sv/multilevel_round_robin_scheduler_top.sv
// Top level of the multilevel round-robin scheduler: front queue plus back sequencer.
// Depends on mlrr_pkg, mlrr_fifo, mlrr_exec, mlrr_ram.
//
//   channel | dir | handshake           | word
//   in      | in  | in_valid/in_ready   | in_word_t (req_type, task_id, level)
//   out     | out | out_valid/out_ready | out_word_t (result_task, do_switch, ...)
//
// One request at a time in the back end: tick and query skip the list search,
// while run and sleep may search and shift the list entries of a level, one entry
// at a time (at most 16 entries).
// The single list RAM port allows one read or write per cycle.
// Reset: all tasks asleep, no level selected; a clearing pass over every task entry
// empties the task RAM before the first word is taken. The list RAM needs no clearing.
// A waiting result stalls the back end; the queue still takes up to two more words.
`default_nettype none
module multilevel_round_robin_scheduler_top #(
  parameter int unsigned NumTasks      = mlrr_pkg::NumTasksDef,
  parameter int unsigned TasksPerLevel = mlrr_pkg::TasksPerLevelDef,
  parameter int unsigned NumLevels     = mlrr_pkg::NumLevelsDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  mlrr_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output mlrr_pkg::out_word_t out_word_o
);
  import mlrr_pkg::*;

  logic     q_full, q_empty, q_pop;
  in_word_t q_word;

  assign in_ready_o = !q_full;

  mlrr_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(in_valid_i && in_ready_o), .wdata_i(in_word_i), .full_o(q_full),
    .pop_i(q_pop), .empty_o(q_empty), .rdata_o(q_word)
  );

  mlrr_exec #(
    .NumTasks(NumTasks), .TasksPerLevel(TasksPerLevel), .NumLevels(NumLevels)
  ) u_exec (
    .clk_i, .rst_ni,
    .req_valid_i(!q_empty), .req_i(q_word), .req_pop_o(q_pop),
    .out_valid_o, .out_ready_i, .out_o(out_word_o)
  );

  // queue never pops when empty
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty)
    else $error("pop from empty queue");
  // a waiting result is not overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result dropped");
  // status is one of the defined codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.status == ST_DONE || out_word_o.status == ST_IGNORED ||
                     out_word_o.status == ST_FULL))
    else $error("bad status");
endmodule
`default_nettype wire
